>>> hw/rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Types and constants shared by the substring replace stream unit.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int PATTERN_MAX    = 8;
  localparam int REPLACE_MAX    = 8;
  localparam int COUNT_BITS     = 16;
  localparam int LEN_BITS       = 16;
  localparam int FILL_BITS      = 4;
  localparam int WIN_IDX_BITS   = $clog2(PATTERN_MAX);
  localparam int REP_IDX_BITS   = $clog2(REPLACE_MAX);
  localparam int WORD_BITS      = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [FILL_BITS-1:0]  PATTERN_MAX_F = FILL_BITS'(PATTERN_MAX);
  localparam logic [FILL_BITS-1:0]  REPLACE_MAX_F = FILL_BITS'(REPLACE_MAX);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   LEN_MAX       = {LEN_BITS{1'b1}};
  localparam logic [LEN_BITS-1:0]   CAPACITY_RESET = LEN_MAX;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_BYTES      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LENGTH     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLACEMENT_LENGTH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OUTPUT_CAPACITY    = 3'd4;

  typedef struct packed {
    logic [WORD_BITS-1:0] pattern_bytes;
    logic [FILL_BITS-1:0] pattern_length;
    logic [WORD_BITS-1:0] replacement_bytes;
    logic [FILL_BITS-1:0] replacement_length;
    logic [LEN_BITS-1:0]  output_capacity;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_REPL,
    CMD_FINAL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [BYTE_BITS-1:0] value;
  } cmd_t;

  typedef enum logic {
    FRONT_RUN,
    FRONT_FLUSH
  } front_state_t;

endpackage

>>> hw/rtl/srs_in_if.sv
// ----------------------------------------------------------------------------
// srs_in_if
// Text channel: one text byte or an end marker per transfer.
// ----------------------------------------------------------------------------
interface srs_in_if import srs_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] text_byte;
  logic                 end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);

endinterface

>>> hw/rtl/srs_out_if.sv
// ----------------------------------------------------------------------------
// srs_out_if
// Result channel: one output byte or the closing length report per transfer.
// ----------------------------------------------------------------------------
interface srs_out_if import srs_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] out_byte;
  logic                 byte_valid;
  logic                 final_res;
  logic [LEN_BITS-1:0]  required_length;

  modport source (output valid, output out_byte, output byte_valid, output final_res,
                  output required_length, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input final_res,
                  input required_length, output ready);

endinterface

>>> hw/rtl/srs_front.sv
// ----------------------------------------------------------------------------
// srs_front
// Accepts text items, keeps the match window and issues commands to the queue.
// ----------------------------------------------------------------------------
module srs_front import srs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  srs_in_if.sink        text,
  input  cfg_t          cfg,
  input  logic          clear,
  input  logic          full,
  output logic          push,
  output cmd_t          push_entry
);

  front_state_t         state, state_next;
  logic [BYTE_BITS-1:0] window [PATTERN_MAX];
  logic [BYTE_BITS-1:0] window_next [PATTERN_MAX];
  logic [BYTE_BITS-1:0] win_ins [PATTERN_MAX];
  logic [FILL_BITS-1:0] fill, fill_next, fill_ins;
  logic [FILL_BITS-1:0] plen;
  logic                 take;
  logic                 hit;

  assign plen = (cfg.pattern_length > PATTERN_MAX_F) ? PATTERN_MAX_F : cfg.pattern_length;
  assign text.ready = (state == FRONT_RUN) && !full;
  assign take = text.valid && text.ready;

  always_comb begin
    state_next  = state;
    window_next = window;
    fill_next   = fill;
    push        = 1'b0;
    push_entry  = '{kind: CMD_BYTE, value: '0};
    win_ins     = window;
    fill_ins    = fill + FILL_BITS'(1);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (WIN_IDX_BITS'(i) == fill[WIN_IDX_BITS-1:0]) begin
        win_ins[i] = text.text_byte;
      end
    end
    hit = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if ((FILL_BITS'(i) < plen) &&
          (win_ins[i] != cfg.pattern_bytes[i*BYTE_BITS +: BYTE_BITS])) begin
        hit = 1'b0;
      end
    end

    unique case (state)
      FRONT_RUN: begin
        if (take) begin
          if (text.end_of_text) begin
            state_next = FRONT_FLUSH;
          end else if (plen == '0) begin
            push       = 1'b1;
            push_entry = '{kind: CMD_BYTE, value: text.text_byte};
          end else begin
            window_next = win_ins;
            fill_next   = fill_ins;
            if (fill_ins >= plen) begin
              push = 1'b1;
              if (hit) begin
                push_entry = '{kind: CMD_REPL, value: '0};
                fill_next  = '0;
              end else begin
                // No match: the oldest byte leaves and the window slides on.
                push_entry = '{kind: CMD_BYTE, value: win_ins[0]};
                for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                  window_next[i] = win_ins[i+1];
                end
                window_next[PATTERN_MAX-1] = '0;
                fill_next = fill_ins - FILL_BITS'(1);
              end
            end
          end
        end
      end
      FRONT_FLUSH: begin
        if (!full) begin
          push = 1'b1;
          if (fill != '0) begin
            push_entry = '{kind: CMD_BYTE, value: window[0]};
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
              window_next[i] = window[i+1];
            end
            window_next[PATTERN_MAX-1] = '0;
            fill_next = fill - FILL_BITS'(1);
          end else begin
            push_entry = '{kind: CMD_FINAL, value: '0};
            state_next = FRONT_RUN;
          end
        end
      end
      default: begin
        state_next = FRONT_RUN;
      end
    endcase

    // A new pattern length throws away whatever the window holds.
    if (clear) begin
      fill_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FRONT_RUN;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    window <= window_next;
  end

endmodule

>>> hw/rtl/srs_queue.sv
// ----------------------------------------------------------------------------
// srs_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module srs_queue import srs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_entry,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_BITS-1:0] count;
  logic                   do_push, do_pop;

  assign full    = (count == QCOUNT_BITS'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCOUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCOUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> hw/rtl/srs_back.sv
// ----------------------------------------------------------------------------
// srs_back
// Carries out queued commands, keeps the output counts and drives results.
// ----------------------------------------------------------------------------
module srs_back import srs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  cmd_t          head,
  input  logic          empty,
  output logic          pop,
  srs_out_if.source     result
);

  logic                    out_valid;
  logic [BYTE_BITS-1:0]    out_byte;
  logic                    out_bval;
  logic                    out_final;
  logic [LEN_BITS-1:0]     out_len;
  logic [REP_IDX_BITS-1:0] idx, idx_next;
  logic [LEN_BITS-1:0]     written, written_next;
  logic [COUNT_BITS-1:0]   needed, needed_next;
  logic [FILL_BITS-1:0]    rlen;
  logic                    step, emit, load_byte, load_final;
  logic [BYTE_BITS-1:0]    emit_byte;
  logic [LEN_BITS-1:0]     sat_len;

  assign rlen = (cfg.replacement_length > REPLACE_MAX_F) ? REPLACE_MAX_F
                                                         : cfg.replacement_length;
  // The output register either is free or empties in this cycle.
  assign step = !empty && (!out_valid || result.ready);
  assign sat_len = (33'(needed) > 33'(LEN_MAX)) ? LEN_MAX : LEN_BITS'(needed);

  always_comb begin
    pop          = 1'b0;
    emit         = 1'b0;
    emit_byte    = head.value;
    idx_next     = idx;
    written_next = written;
    needed_next  = needed;
    load_byte    = 1'b0;
    load_final   = 1'b0;
    if (step) begin
      unique case (head.kind)
        CMD_BYTE: begin
          emit = 1'b1;
          pop  = 1'b1;
        end
        CMD_REPL: begin
          if (rlen == '0) begin
            pop = 1'b1;
          end else begin
            emit      = 1'b1;
            emit_byte = cfg.replacement_bytes[idx*BYTE_BITS +: BYTE_BITS];
            if ((FILL_BITS'(idx) + FILL_BITS'(1)) == rlen) begin
              pop      = 1'b1;
              idx_next = '0;
            end else begin
              idx_next = idx + REP_IDX_BITS'(1);
            end
          end
        end
        CMD_FINAL: begin
          load_final   = 1'b1;
          pop          = 1'b1;
          written_next = '0;
          needed_next  = '0;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
    if (emit) begin
      if (needed != COUNT_MAX) begin
        needed_next = needed + COUNT_BITS'(1);
      end
      // One place is kept back for the terminator of the destination.
      if (((LEN_BITS+1)'(written) + (LEN_BITS+1)'(1)) < (LEN_BITS+1)'(cfg.output_capacity))
      begin
        load_byte    = 1'b1;
        written_next = written + LEN_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      written   <= '0;
      needed    <= '0;
    end else begin
      idx     <= idx_next;
      written <= written_next;
      needed  <= needed_next;
      if (load_byte || load_final) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_byte) begin
      out_byte  <= emit_byte;
      out_bval  <= 1'b1;
      out_final <= 1'b0;
      out_len   <= '0;
    end else if (load_final) begin
      out_byte  <= '0;
      out_bval  <= 1'b0;
      out_final <= 1'b1;
      out_len   <= sat_len;
    end
  end

  assign result.valid           = out_valid;
  assign result.out_byte        = out_byte;
  assign result.byte_valid      = out_bval;
  assign result.final_res       = out_final;
  assign result.required_length = out_len;

endmodule

>>> hw/rtl/substring_replace_stream_unit.sv
// ----------------------------------------------------------------------------
// substring_replace_stream_unit
// Streaming find-and-replace over a byte text with a closing length report.
// ----------------------------------------------------------------------------
// The text channel takes one text byte per transfer; a transfer with
// end_of_text set closes the text. The result channel gives the output bytes
// in order and then one final result carrying the required output length.
// Registers are to be written through the plain write port only while the
// block is idle; the user must keep to this, the block does not enforce it.
//
// A result passes from the front through the queue to the output register.
// Throughput: one text byte per cycle while the command queue has room. A
// match makes the back part emit the replacement bytes in turn, or just pop
// the command when replacement_length is zero, so long replacements fill
// the four-entry queue and hold off the text channel. An end item holds the
// text channel while the front drains the window into the queue and then
// pushes the final command. When the receiver stalls, the output register
// holds its result, the back part stops, the queue fills and the text channel
// drops ready. Reset empties the window, the queue and the output register,
// clears the counts and sets the registers to their reset values.
// ----------------------------------------------------------------------------
module substring_replace_stream_unit import srs_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  srs_in_if.sink                    text,
  srs_out_if.source                 result,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]      cfg_data
);

  cfg_t cfg;
  logic clear;
  logic push, q_full, q_empty, pop;
  cmd_t push_entry, head;

  assign clear = cfg_write && (cfg_index == CFG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes      <= '0;
      cfg.pattern_length     <= '0;
      cfg.replacement_bytes  <= '0;
      cfg.replacement_length <= '0;
      cfg.output_capacity    <= CAPACITY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_PATTERN_BYTES:      cfg.pattern_bytes      <= cfg_data;
        CFG_PATTERN_LENGTH:     cfg.pattern_length     <= cfg_data[FILL_BITS-1:0];
        CFG_REPLACEMENT_BYTES:  cfg.replacement_bytes  <= cfg_data;
        CFG_REPLACEMENT_LENGTH: cfg.replacement_length <= cfg_data[FILL_BITS-1:0];
        CFG_OUTPUT_CAPACITY:    cfg.output_capacity    <= cfg_data[LEN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  srs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .cfg        (cfg),
    .clear      (clear),
    .full       (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  srs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  srs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .result (result)
  );

`ifndef NO_ASSERTIONS
  // The front never offers a command that the queue cannot take.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("command pushed into a full queue");

  // After an end transfer the text channel waits while the window drains.
  a_end_blocks: assert property (@(posedge clk) disable iff (rst)
    (text.valid && text.ready && text.end_of_text) |=> !text.ready)
    else $error("text accepted during window flush");

  // The back only pops what the queue holds.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("pop from an empty queue");

  // A final result never carries an output byte.
  a_final_clean: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.final_res) |-> !result.byte_valid)
    else $error("final result flagged as a byte");
`endif

endmodule
